@@ src/lcaam_pkg.sv @@
`default_nettype none

package lcaam_pkg;

    localparam int FUNC_W      = 2;
    localparam int ENTRY_W     = 4;
    localparam int VALUE_W     = 64;
    localparam int TYPE_W      = 3;
    localparam int COUNT_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    // item kinds, codes follow the func field
    typedef enum logic [FUNC_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ELEM  = 2'd1,
        OP_NULL  = 2'd2,
        OP_EMPTY = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT    = 2'd2;

    localparam logic MODE_ALL = 1'b0;
    localparam logic MODE_ANY = 1'b1;

    localparam logic [TYPE_W-1:0] TY_INT32  = 3'd0;
    localparam logic [TYPE_W-1:0] TY_UINT32 = 3'd1;
    localparam logic [TYPE_W-1:0] TY_INT64  = 3'd2;
    localparam logic [TYPE_W-1:0] TY_UINT64 = 3'd3;
    localparam logic [TYPE_W-1:0] TY_FLOAT  = 3'd4;
    localparam logic [TYPE_W-1:0] TY_DOUBLE = 3'd5;
    localparam logic [TYPE_W-1:0] TY_BOOL   = 3'd6;

    typedef struct packed {
        logic               match_mode;
        logic [TYPE_W-1:0]  element_type;
        logic [COUNT_W-1:0] set_count;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [ENTRY_W-1:0] entry_index;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               el_nan;
        logic               el_zero;
    } cmd_t;

    function automatic logic val_nan(logic [VALUE_W-1:0] v, logic [TYPE_W-1:0] ty);
        logic r;
        r = 1'b0;
        case (ty)
            TY_FLOAT:  r = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
            TY_DOUBLE: r = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

    // magnitude zero, so that +0 and -0 meet
    function automatic logic val_zero(logic [VALUE_W-1:0] v, logic [TYPE_W-1:0] ty);
        logic r;
        r = 1'b0;
        case (ty)
            TY_FLOAT:  r = (v[30:0] == 31'd0);
            TY_DOUBLE: r = (v[62:0] == 63'd0);
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic elem_match(
        logic [VALUE_W-1:0] a,
        logic [VALUE_W-1:0] b,
        logic               a_nan,
        logic               a_zero,
        logic               b_nan,
        logic               b_zero,
        logic [TYPE_W-1:0]  ty
    );
        logic r;
        r = 1'b0;
        case (ty) inside
            TY_INT32, TY_UINT32: r = (a[31:0] == b[31:0]);
            TY_INT64, TY_UINT64: r = (a == b);
            TY_FLOAT:  r = !a_nan && !b_nan && ((a_zero && b_zero) || (a[31:0] == b[31:0]));
            TY_DOUBLE: r = !a_nan && !b_nan && ((a_zero && b_zero) || (a == b));
            TY_BOOL:   r = (a[0] == b[0]);
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/lcaam_if.sv @@
`default_nettype none

interface lcaam_in_if;
    logic                             valid;
    logic                             ready;
    logic [lcaam_pkg::FUNC_W-1:0]     func;
    logic [lcaam_pkg::ENTRY_W-1:0]    entry_index;
    logic [lcaam_pkg::VALUE_W-1:0]    element_value;
    logic                             last_element;

    modport source (output valid, func, entry_index, element_value, last_element,
                    input ready);
    modport sink   (input valid, func, entry_index, element_value, last_element,
                    output ready);
endinterface

interface lcaam_out_if;
    logic valid;
    logic ready;
    logic row_match;
    logic row_null;

    modport source (output valid, row_match, row_null, input ready);
    modport sink   (input valid, row_match, row_null, output ready);
endinterface

interface lcaam_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lcaam_pkg::CFG_IDX_W-1:0]   index;
    logic [lcaam_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/list_contains_all_any_match_core.sv @@
// Path: a word accepted on item passes through the front register, the two-word queue,
// the compare stage and the output register; a row end then gives its result on result.
// Throughput: one word per cycle; all set entries are compared in parallel lanes.
// Loads, non-last elements and row ends are all taken at this rate; output stalls hold the back end.
// Reset: rst_n clears the config registers, the queue pointers and count, the found mask and all
// valid flags; set entries keep whatever they hold until loaded.
`default_nettype none

module list_contains_all_any_match_core #(
    parameter int SET_SIZE = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lcaam_in_if.sink    item,
    lcaam_out_if.source result,
    lcaam_cfg_if.sink   cfg
);

    lcaam_pkg::cfg_t cfg_reg;
    logic            q_push_valid;
    logic            q_push_ready;
    lcaam_pkg::cmd_t q_push_data;
    logic            q_pop_valid;
    logic            q_pop_ready;
    lcaam_pkg::cmd_t q_pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_mode   <= lcaam_pkg::MODE_ALL;
            cfg_reg.element_type <= lcaam_pkg::TY_INT32;
            cfg_reg.set_count    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lcaam_pkg::CFG_MATCH_MODE:   cfg_reg.match_mode   <= cfg.data[0];
                lcaam_pkg::CFG_ELEMENT_TYPE: cfg_reg.element_type <= cfg.data[2:0];
                lcaam_pkg::CFG_SET_COUNT:    cfg_reg.set_count    <= cfg.data[4:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    lcaam_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg_reg),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    lcaam_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    lcaam_back #(
        .SET_SIZE (SET_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .cfg       (cfg_reg),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ src/lcaam_front.sv @@
`default_nettype none

module lcaam_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    lcaam_in_if.sink             item,
    input  wire lcaam_pkg::cfg_t cfg,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output lcaam_pkg::cmd_t      push_data
);

    logic            f_valid_reg;
    logic            f_valid_next;
    lcaam_pkg::cmd_t f_cmd_reg;
    lcaam_pkg::cmd_t f_cmd_next;
    logic            take;

    assign item.ready = !f_valid_reg || push_ready;
    assign take       = item.valid && item.ready;
    assign push_valid = f_valid_reg;
    assign push_data  = f_cmd_reg;

    always_comb
    begin
        f_cmd_next             = f_cmd_reg;
        f_cmd_next.entry_index = item.entry_index;
        f_cmd_next.value       = item.element_value;
        f_cmd_next.last        = item.last_element;
        f_cmd_next.el_nan      = lcaam_pkg::val_nan(item.element_value, cfg.element_type);
        f_cmd_next.el_zero     = lcaam_pkg::val_zero(item.element_value, cfg.element_type);
        // every func code is an item kind
        f_cmd_next.op          = lcaam_pkg::op_t'(item.func);
    end

    always_comb
    begin
        if (take)
        begin
            f_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            f_valid_next = 1'b0;
        end
        else
        begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_cmd_reg <= f_cmd_next;
        end
    end

endmodule

`default_nettype wire

@@ src/lcaam_queue.sv @@
`default_nettype none

module lcaam_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire lcaam_pkg::cmd_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output lcaam_pkg::cmd_t      pop_data
);

    lcaam_pkg::cmd_t                    mem_reg [lcaam_pkg::Q_DEPTH];
    logic [lcaam_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [lcaam_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [lcaam_pkg::Q_CNT_W-1:0]      cnt_reg;
    logic [lcaam_pkg::Q_CNT_W-1:0]      cnt_next;
    logic                               push;
    logic                               pop;

    assign push_ready = (cnt_reg != lcaam_pkg::Q_CNT_W'(lcaam_pkg::Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/lcaam_back.sv @@
`default_nettype none

module lcaam_back #(
    parameter int SET_SIZE = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire lcaam_pkg::cmd_t pop_data,
    input  wire lcaam_pkg::cfg_t cfg,
    lcaam_out_if.source          result
);

    logic [lcaam_pkg::VALUE_W-1:0] set_reg [SET_SIZE];
    logic [SET_SIZE-1:0]           lane_en;
    logic [SET_SIZE-1:0]           hit_next;
    logic [SET_SIZE-1:0]           hit_reg;
    logic [SET_SIZE-1:0]           found_reg;
    logic [SET_SIZE-1:0]           found_next;
    logic [SET_SIZE-1:0]           found_or;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    lcaam_pkg::op_t                s1_op_reg;
    logic [lcaam_pkg::ENTRY_W-1:0] s1_idx_reg;
    logic                          s1_last_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          match_reg;
    logic                          match_next;
    logic                          null_reg;
    logic                          null_next;

    logic                          adv;
    logic                          s1_load;
    logic                          row_end;
    logic                          all_found;
    logic                          any_found;

    // second stage moves only while the output word can leave
    assign adv       = !out_valid_reg || result.ready;
    assign s1_load   = pop_valid && (!s1_valid_reg || adv);
    assign pop_ready = !s1_valid_reg || adv;

    genvar j;
    generate
        for (j = 0; j < SET_SIZE; j++)
        begin : g_lane
            assign lane_en[j] = (int'(cfg.set_count) > j);

            assign hit_next[j] = lane_en[j] && lcaam_pkg::elem_match(
                pop_data.value, set_reg[j], pop_data.el_nan, pop_data.el_zero,
                lcaam_pkg::val_nan(set_reg[j], cfg.element_type),
                lcaam_pkg::val_zero(set_reg[j], cfg.element_type),
                cfg.element_type);

            always_ff @(posedge clk)
            begin
                if (s1_load && (pop_data.op == lcaam_pkg::OP_LOAD)
                    && (int'(pop_data.entry_index) == j))
                begin
                    set_reg[j] <= pop_data.value;
                end
            end
        end
    endgenerate

    assign found_or  = found_reg | hit_reg;
    assign all_found = &(found_or | ~lane_en);
    assign any_found = |(found_or & lane_en);
    assign row_end   = (s1_op_reg == lcaam_pkg::OP_NULL) || (s1_op_reg == lcaam_pkg::OP_EMPTY)
                       || ((s1_op_reg == lcaam_pkg::OP_ELEM) && s1_last_reg);

    always_comb
    begin
        found_next = found_reg;
        match_next = 1'b0;
        null_next  = 1'b0;
        if (adv && s1_valid_reg)
        begin
            unique case (s1_op_reg)
                lcaam_pkg::OP_LOAD:
                begin
                    // a fresh entry has not been compared yet
                    for (int k = 0; k < SET_SIZE; k++)
                    begin
                        if (int'(s1_idx_reg) == k)
                        begin
                            found_next[k] = 1'b0;
                        end
                    end
                end
                lcaam_pkg::OP_ELEM:
                begin
                    if (s1_last_reg)
                    begin
                        found_next = '0;
                        match_next = (cfg.match_mode == lcaam_pkg::MODE_ALL) ? all_found
                                                                             : any_found;
                    end
                    else
                    begin
                        found_next = found_or;
                    end
                end
                lcaam_pkg::OP_NULL:
                begin
                    found_next = '0;
                    null_next  = 1'b1;
                end
                default:
                begin
                    found_next = '0;
                    match_next = (cfg.match_mode == lcaam_pkg::MODE_ALL)
                                 && (cfg.set_count == '0);
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv && s1_valid_reg && row_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg   <= pop_data.op;
            s1_idx_reg  <= pop_data.entry_index;
            s1_last_reg <= pop_data.last;
            hit_reg     <= hit_next;
        end
        if (adv && s1_valid_reg && row_end)
        begin
            match_reg <= match_next;
            null_reg  <= null_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.row_match = match_reg;
    assign result.row_null  = null_reg;

    a_null_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && null_reg) |-> !match_reg)
        else $error("null row reported with a match");

    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_valid_reg && row_end) |=> (found_reg == '0))
        else $error("found mask not cleared at row end");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> (s1_valid_reg && $stable(hit_reg) && $stable(s1_op_reg)))
        else $error("stage one lost its word under stall");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result raised without a word in stage one");

endmodule

`default_nettype wire
